/* sv/fast_inverse_sqrt_defines.svh */
// ---------------------------------------------------------------------------
// fast_inverse_sqrt_defines.svh
// Assertion macros for the checker file.
// ---------------------------------------------------------------------------
`ifndef FAST_INVERSE_SQRT_DEFINES_SVH
`define FAST_INVERSE_SQRT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define FIS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fast_inverse_sqrt: same-cycle check failed");

// Next-cycle implication, sampled on clock, never disabled.
`define FIS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("fast_inverse_sqrt: next-cycle check failed");

`endif

/* sv/fis_pkg.sv */
// ---------------------------------------------------------------------------
// fis_pkg
// Types, constants and single-precision arithmetic helpers for the
// fast inverse square root pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package fis_pkg;

   localparam logic [31:0] MAGIC_GUESS  = 32'h5f3759df;
   localparam logic [31:0] HALF_BITS    = 32'h3f000000;
   localparam logic [31:0] THREE_HALVES = 32'h3fc00000;
   localparam logic [31:0] CANON_NAN    = 32'h7fc00000;
   localparam logic [30:0] INF_MAG      = 31'h7f800000;
   localparam int          LATENCY      = 11;

   localparam logic [1:0] KIND_NUM  = 2'd0;
   localparam logic [1:0] KIND_ZERO = 2'd1;
   localparam logic [1:0] KIND_INF  = 2'd2;
   localparam logic [1:0] KIND_NAN  = 2'd3;

   // Unrounded value: mant / 2^63 * 2^(expo - 127), expo biased.
   typedef struct packed {
      logic [1:0]         kind;
      logic               sign;
      logic signed [11:0] expo;
      logic [63:0]        mant;
   } unp_type;

   function automatic unp_type fmul_a(input logic [31:0] a, input logic [31:0] b);
      logic [7:0]  ea;
      logic [7:0]  eb;
      logic [23:0] ma;
      logic [23:0] mb;
      logic [47:0] p;
      logic        za, zb, ia, ib, na, nb;
      unp_type     u;
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma = {|a[30:23], a[22:0]};
      mb = {|b[30:23], b[22:0]};
      za = (a[30:0] == 31'd0);
      zb = (b[30:0] == 31'd0);
      ia = (a[30:0] == INF_MAG);
      ib = (b[30:0] == INF_MAG);
      na = (a[30:0] > INF_MAG);
      nb = (b[30:0] > INF_MAG);
      p  = ma * mb;
      u.sign = a[31] ^ b[31];
      u.mant = {p, 16'd0};
      u.expo = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126;
      if (na || nb || (ia && zb) || (za && ib)) begin
         u.kind = KIND_NAN;
      end else if (ia || ib) begin
         u.kind = KIND_INF;
      end else if (za || zb) begin
         u.kind = KIND_ZERO;
      end else begin
         u.kind = KIND_NUM;
      end
      return u;
   endfunction

   function automatic unp_type fadd_a(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] l;
      logic [31:0] s;
      logic [7:0]  el;
      logic [7:0]  es;
      logic [7:0]  d;
      logic [50:0] x;
      logic [50:0] yf;
      logic [50:0] y;
      logic [50:0] sum;
      logic        na, nb, ia, ib;
      unp_type     u;
      if (b[30:0] > a[30:0]) begin
         l = b;
         s = a;
      end else begin
         l = a;
         s = b;
      end
      el = (l[30:23] == 8'd0) ? 8'd1 : l[30:23];
      es = (s[30:23] == 8'd0) ? 8'd1 : s[30:23];
      d  = el - es;
      x  = {1'b0, |l[30:23], l[22:0], 26'd0};
      yf = {1'b0, |s[30:23], s[22:0], 26'd0};
      y  = yf >> d;
      // fold shifted-out bits into a sticky lsb
      y[0] = y[0] | ((y << d) != yf);
      sum = (l[31] == s[31]) ? (x + y) : (x - y);
      na = (a[30:0] > INF_MAG);
      nb = (b[30:0] > INF_MAG);
      ia = (a[30:0] == INF_MAG);
      ib = (b[30:0] == INF_MAG);
      u.sign = l[31];
      u.mant = {sum, 13'd0};
      u.expo = $signed({4'd0, el}) + 12'sd1;
      if (na || nb || (ia && ib && (a[31] != b[31]))) begin
         u.kind = KIND_NAN;
      end else if (ia || ib) begin
         u.kind = KIND_INF;
         u.sign = ia ? a[31] : b[31];
      end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
         u.kind = KIND_ZERO;
         u.sign = a[31] & b[31];
      end else if (sum == 51'd0) begin
         u.kind = KIND_ZERO;
         u.sign = 1'b0;
      end else begin
         u.kind = KIND_NUM;
      end
      return u;
   endfunction

   function automatic logic [31:0] fround(input unp_type u);
      logic [5:0]         lz;
      logic [63:0]        m;
      logic signed [12:0] e;
      logic signed [12:0] dn;
      logic [6:0]         sh;
      logic [127:0]       w;
      logic [23:0]        q;
      logic               rb;
      logic               st;
      logic               inc;
      logic [33:0]        pk;
      logic [31:0]        r;
      lz = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (u.mant[i]) begin
            lz = 6'(63 - i);
         end
      end
      m = u.mant << lz;
      e = $signed({u.expo[11], u.expo}) - $signed({7'd0, lz});
      w = {m, 64'd0};
      if (e < 13'sd1) begin
         dn = 13'sd1 - e;
         sh = (dn > 13'sd100) ? 7'd100 : dn[6:0];
         w  = w >> sh;
         e  = 13'sd1;
      end
      q   = w[127:104];
      rb  = w[103];
      st  = |w[102:0];
      inc = rb & (st | q[0]);
      // hidden bit carries into the exponent field, rounding carry too
      pk  = ({21'd0, 13'(e - 13'sd1)} << 23) + {10'd0, q} + {33'd0, inc};
      case (u.kind)
         KIND_NAN:  r = CANON_NAN;
         KIND_INF:  r = {u.sign, INF_MAG};
         KIND_ZERO: r = {u.sign, 31'd0};
         default: begin
            if (pk >= {3'd0, INF_MAG}) begin
               r = {u.sign, INF_MAG};
            end else begin
               r = {u.sign, pk[30:0]};
            end
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/fast_inverse_sqrt.sv */
// Throughput: one item per cycle while busy is low; busy is high during
// reset and in the cycle after it. Five float operations, each split into
// a multiply/align stage and a normalize/round stage, behind one input
// register that forms the guess.
// Reset (synchronous) clears all valid bits; items in flight are dropped.
// ---------------------------------------------------------------------------
// fast_inverse_sqrt
// Bit-exact single-precision fast inverse square root with one Newton step.
// ---------------------------------------------------------------------------
`default_nettype none

module fast_inverse_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_number_bits,
   output logic             rsp_strobe,
   output logic [31:0]      rsp_result_bits
);

   logic [10:0]      valid_ff;
   logic [10:0]      valid_in;
   logic             busy_ff;
   logic [31:0]      x0_ff;
   logic [31:0]      g_ff [0:8];
   logic [31:0]      g_in;
   fis_pkg::unp_type u1_ff, u3_ff, u5_ff, u7_ff, u9_ff;
   fis_pkg::unp_type u1_in, u3_in, u5_in, u7_in, u9_in;
   logic [31:0]      b2_ff, b4_ff, b6_ff, b8_ff, y_ff;

   assign busy     = busy_ff;
   assign valid_in = {valid_ff[9:0], start & ~busy_ff};
   assign g_in     = fis_pkg::MAGIC_GUESS - {req_number_bits[31], req_number_bits[31:1]};

   assign u1_in = fis_pkg::fmul_a(x0_ff, fis_pkg::HALF_BITS);
   assign u3_in = fis_pkg::fmul_a(b2_ff, g_ff[2]);
   assign u5_in = fis_pkg::fmul_a(b4_ff, g_ff[4]);
   // 1.5 - t as an add with the sign flipped
   assign u7_in = fis_pkg::fadd_a(fis_pkg::THREE_HALVES, {~b6_ff[31], b6_ff[30:0]});
   assign u9_in = fis_pkg::fmul_a(g_ff[8], b8_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         busy_ff  <= 1'b1;
      end else begin
         valid_ff <= valid_in;
         busy_ff  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff   <= req_number_bits;
      g_ff[0] <= g_in;
      for (int i = 1; i < 9; i++) begin
         g_ff[i] <= g_ff[i - 1];
      end
      u1_ff <= u1_in;
      b2_ff <= fis_pkg::fround(u1_ff);
      u3_ff <= u3_in;
      b4_ff <= fis_pkg::fround(u3_ff);
      u5_ff <= u5_in;
      b6_ff <= fis_pkg::fround(u5_ff);
      u7_ff <= u7_in;
      b8_ff <= fis_pkg::fround(u7_ff);
      u9_ff <= u9_in;
      y_ff  <= fis_pkg::fround(u9_ff);
   end

   assign rsp_strobe      = valid_ff[10];
   assign rsp_result_bits = y_ff;

endmodule

`default_nettype wire

/* sv/fis_checker.sv */
// ---------------------------------------------------------------------------
// fis_checker
// Port-level checks on the fast inverse square root, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "fast_inverse_sqrt_defines.svh"

module fis_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic [31:0] req_number_bits,
   input wire logic        rsp_strobe,
   input wire logic [31:0] rsp_result_bits
);

   logic nan_out;
   logic unused_ok;

   assign nan_out   = rsp_result_bits[30:0] > fis_pkg::INF_MAG;
   assign unused_ok = ^req_number_bits;

   // every result traces back to an item accepted a fixed time earlier
   `FIS_ASSERT_IMPL(a_strobe_has_item, rsp_strobe, $past(start && !busy, fis_pkg::LATENCY))
   // NaN results leave only in canonical form
   `FIS_ASSERT_IMPL(a_nan_canonical, rsp_strobe && nan_out, rsp_result_bits == fis_pkg::CANON_NAN)
   // reset drops anything in flight
   `FIS_ASSERT_NEXT(a_reset_clears, reset, !rsp_strobe && (busy || unused_ok || !unused_ok))

endmodule

bind fast_inverse_sqrt fis_checker u_fis_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_number_bits (req_number_bits),
   .rsp_strobe      (rsp_strobe),
   .rsp_result_bits (rsp_result_bits)
);

`default_nettype wire
